[design/tiled_texture_deswizzle_decode_top_defines.svh]
// Assertion macros shared by the texture decode modules.
// Each macro carries its own label, clock and property; in synthesis they expand to nothing.
`ifndef TILED_TEXTURE_DESWIZZLE_DECODE_TOP_DEFINES_SVH
`define TILED_TEXTURE_DESWIZZLE_DECODE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TTDD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TTDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTDD_ASSERT(lbl, clk, rstn, prop, msg)
`define TTDD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/ttdd_pkg.sv]
package ttdd_pkg;

    // Image geometry.
    localparam int MAX_DIM   = 1024;
    localparam int TILE_SIZE = 8;
    localparam int TILE_BITS = $clog2(TILE_SIZE);
    localparam int COORD_W   = $clog2(MAX_DIM);
    localparam int TILE_W    = COORD_W - TILE_BITS;
    localparam int CDIM_W    = COORD_W + 1;
    localparam int IDX_W     = 2 * TILE_BITS;

    // Fixed field widths.
    localparam int TEXEL_W = 32;
    localparam int PIX_W   = 10;
    localparam int CHAN_W  = 8;
    localparam int FMT_W   = 3;
    localparam int DIM_W   = 11;
    localparam int CFG_IDX_W = 2;

    // Queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef logic [TEXEL_W-1:0] t_texel;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [TILE_W-1:0]  t_tile;
    typedef logic [CDIM_W-1:0]  t_cdim;
    typedef logic [DIM_W-1:0]   t_dim;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [FMT_W-1:0]   t_fmt;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Pixel format codes.
    localparam t_fmt FMT_IA8      = 3'd0;
    localparam t_fmt FMT_RGB8     = 3'd1;
    localparam t_fmt FMT_RGBA5551 = 3'd2;
    localparam t_fmt FMT_RGBA4    = 3'd3;
    localparam t_fmt FMT_RGBA8    = 3'd4;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_FORMAT = 2'd0;
    localparam t_cfg_idx CFG_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_HEIGHT = 2'd2;

    // Last index within a tile.
    localparam t_idx IDX_LAST = t_idx'((1 << IDX_W) - 1);

    // Geometry derived from the dimension registers.
    typedef struct packed {
        t_cdim width;
        t_cdim height;
        t_tile last_col;
        t_tile last_row;
    } t_geom;

    // One classified texel on its way to the decoder.
    typedef struct packed {
        t_texel raw;
        t_coord x;
        t_coord y;
        logic   in_image;
        logic   done;
    } t_item;

    // A dimension of zero counts as one, anything above the maximum as the maximum.
    function automatic t_cdim clamp_dim(input t_dim d);
        t_cdim c;
        if (d == '0) begin
            c = t_cdim'(1);
        end else if (int'(d) > MAX_DIM) begin
            c = t_cdim'(MAX_DIM);
        end else begin
            c = t_cdim'(d);
        end
        return c;
    endfunction

    // Index of the last tile along a dimension padded to a power of two.
    // Smearing the bits of c-1 gives the padded size less one.
    function automatic t_tile last_tile(input t_cdim c);
        t_cdim m;
        m = c - t_cdim'(1);
        for (int s = 1; s < CDIM_W; s = s * 2) begin
            m = m | (m >> s);
        end
        return t_tile'(m >> TILE_BITS);
    endfunction

endpackage

[design/ttdd_front.sv]
`include "tiled_texture_deswizzle_decode_top_defines.svh"

module ttdd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ttdd_pkg::t_texel i_raw_texel,
    input  ttdd_pkg::t_geom  i_geom,
    input  logic             i_q_full,
    output logic             o_push,
    output ttdd_pkg::t_item  o_push_item
);

    ttdd_pkg::t_idx  r_idx, n_idx;
    ttdd_pkg::t_tile r_col, n_col;
    ttdd_pkg::t_tile r_row, n_row;

    logic accept;
    logic last_col;
    logic last_row;
    logic idx_last;
    logic done;
    logic in_image;
    logic [ttdd_pkg::TILE_BITS-1:0] lx;
    logic [ttdd_pkg::TILE_BITS-1:0] ly;
    ttdd_pkg::t_coord x;
    ttdd_pkg::t_coord y;

    // An item is taken whenever the queue has room.
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // Morton order: even index bits give the column, odd bits the row.
    always_comb begin
        for (int k = 0; k < ttdd_pkg::TILE_BITS; k++) begin
            lx[k] = r_idx[2*k];
            ly[k] = r_idx[2*k+1];
        end
    end

    assign x = {r_col, lx};
    assign y = {r_row, ly};

    // Classification of the current texel.
    assign last_col = r_col >= i_geom.last_col;
    assign last_row = r_row >= i_geom.last_row;
    assign idx_last = r_idx == ttdd_pkg::IDX_LAST;
    assign done     = idx_last && last_col && last_row;
    assign in_image = (ttdd_pkg::t_cdim'(x) < i_geom.width)
                   && (ttdd_pkg::t_cdim'(y) < i_geom.height);

    // Only pixels inside the image, and the frame's last texel, yield a result.
    assign o_push               = accept && (in_image || done);
    assign o_push_item.raw      = i_raw_texel;
    assign o_push_item.x        = x;
    assign o_push_item.y        = y;
    assign o_push_item.in_image = in_image;
    assign o_push_item.done     = done;

    // Stored-order counters advance on every accepted item.
    always_comb begin
        n_idx = r_idx;
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            n_idx = r_idx + ttdd_pkg::t_idx'(1);
            if (idx_last) begin
                if (last_col) begin
                    n_col = '0;
                    n_row = last_row ? '0 : r_row + ttdd_pkg::t_tile'(1);
                end else begin
                    n_col = r_col + ttdd_pkg::t_tile'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_idx <= n_idx;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `TTDD_ASSERT(a_frame_wrap, i_clk, i_rst_n, (accept && done) |=> (r_idx == '0 && r_col == '0 && r_row == '0), "counters did not wrap at frame end")
    `TTDD_ASSERT(a_idx_step, i_clk, i_rst_n, (accept && !idx_last) |=> (r_idx == $past(r_idx) + ttdd_pkg::t_idx'(1)), "index within tile did not advance")
    `TTDD_ASSERT(a_push_full, i_clk, i_rst_n, o_push |-> !i_q_full, "push into a full queue")

endmodule

[design/ttdd_queue.sv]
`include "tiled_texture_deswizzle_decode_top_defines.svh"

module ttdd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ttdd_pkg::t_item i_push_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_not_empty,
    output ttdd_pkg::t_item o_pop_item
);

    ttdd_pkg::t_item r_mem [ttdd_pkg::QDEPTH];

    logic [ttdd_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [ttdd_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [ttdd_pkg::QPTR_W:0]   r_count, n_count;

    assign o_full      = r_count == (ttdd_pkg::QPTR_W+1)'(ttdd_pkg::QDEPTH);
    assign o_not_empty = r_count != '0;
    assign o_pop_item  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (ttdd_pkg::QPTR_W+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (ttdd_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + ttdd_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + ttdd_pkg::QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    `TTDD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= (ttdd_pkg::QPTR_W+1)'(ttdd_pkg::QDEPTH), "queue occupancy beyond depth")
    `TTDD_ASSERT(a_pop_empty, i_clk, i_rst_n, i_pop |-> o_not_empty, "pop from an empty queue")
    `TTDD_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + (ttdd_pkg::QPTR_W+1)'(1)), "occupancy did not grow on push")

endmodule

[design/ttdd_back.sv]
`include "tiled_texture_deswizzle_decode_top_defines.svh"

module ttdd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ttdd_pkg::t_fmt   i_pixel_format,
    input  logic             i_q_not_empty,
    input  ttdd_pkg::t_item  i_q_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ttdd_pkg::t_pix   o_pixel_x,
    output ttdd_pkg::t_pix   o_pixel_y,
    output ttdd_pkg::t_chan  o_alpha,
    output ttdd_pkg::t_chan  o_red,
    output ttdd_pkg::t_chan  o_green,
    output ttdd_pkg::t_chan  o_blue,
    output logic             o_frame_done
);

    logic            r_valid;
    ttdd_pkg::t_pix  r_x;
    ttdd_pkg::t_pix  r_y;
    ttdd_pkg::t_chan r_a, r_r, r_g, r_b;
    logic            r_done;

    ttdd_pkg::t_chan n_a, n_r, n_g, n_b;
    ttdd_pkg::t_chan b0, b1, b2, b3;
    logic [15:0]     v;

    // The output register is refilled when empty or when its item leaves.
    assign o_pop = i_q_not_empty && (!r_valid || i_out_ready);

    assign b0 = i_q_item.raw[7:0];
    assign b1 = i_q_item.raw[15:8];
    assign b2 = i_q_item.raw[23:16];
    assign b3 = i_q_item.raw[31:24];
    assign v  = i_q_item.raw[15:0];

    // Colour decode; pixels outside the image and unknown formats give zero.
    always_comb begin
        n_a = '0;
        n_r = '0;
        n_g = '0;
        n_b = '0;
        if (i_q_item.in_image) begin
            unique case (i_pixel_format)
                ttdd_pkg::FMT_IA8: begin
                    n_a = b0;
                    n_r = b1;
                    n_g = b1;
                    n_b = b1;
                end
                ttdd_pkg::FMT_RGB8: begin
                    n_a = '1;
                    n_r = b2;
                    n_g = b1;
                    n_b = b0;
                end
                ttdd_pkg::FMT_RGBA5551: begin
                    if (v[0]) begin
                        n_a = '1;
                        n_r = {v[15:11], 3'b000};
                        n_g = {v[10:6], 3'b000};
                        n_b = {v[5:1], 3'b000};
                    end
                end
                ttdd_pkg::FMT_RGBA4: begin
                    n_r = {b1[7:4], b1[7:4]};
                    n_g = {b1[3:0], b1[3:0]};
                    n_b = {b0[7:4], b0[7:4]};
                    n_a = {b0[3:0], b0[3:0]};
                end
                ttdd_pkg::FMT_RGBA8: begin
                    n_r = b3;
                    n_g = b2;
                    n_b = b1;
                    n_a = b0;
                end
                default: begin
                    n_a = '0;
                end
            endcase
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x    <= ttdd_pkg::t_pix'(i_q_item.x);
            r_y    <= ttdd_pkg::t_pix'(i_q_item.y);
            r_a    <= n_a;
            r_r    <= n_r;
            r_g    <= n_g;
            r_b    <= n_b;
            r_done <= i_q_item.done;
        end
    end

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_pixel_x    = r_x;
    assign o_pixel_y    = r_y;
    assign o_alpha      = r_a;
    assign o_red        = r_r;
    assign o_green      = r_g;
    assign o_blue       = r_b;
    assign o_frame_done = r_done;

    `TTDD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !r_valid, "output valid straight after reset")
    `TTDD_ASSERT(a_pop_fills, i_clk, i_rst_n, o_pop |=> r_valid, "popped item did not reach the output")
    `TTDD_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_valid && !i_out_ready) |-> !o_pop, "waiting result overwritten")

endmodule

[design/tiled_texture_deswizzle_decode_top.sv]
// Morton-tiled 8x8 texture decoder. Raw texels enter one per cycle while input ready is high,
// in stored tile order, and leave as ARGB8888 pixels with their x and y; texels outside the
// true image give no pixel, except the frame's last texel, which always gives one with
// frame_done set. Sustained rate is one item per cycle while the output is taken; an accepted
// texel is held in the queue, then in the output register. A four-entry queue sits between
// the address/classify front and the colour decode back, and input ready drops only when
// that queue is full. Configuration is taken at any time with ready held high, but must only
// be written while the block holds no item; the derived tile counts are stored at the write.
module tiled_texture_deswizzle_decode_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  ttdd_pkg::t_cfg_idx   i_cfg_index,
    input  ttdd_pkg::t_dim       i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ttdd_pkg::t_texel     i_raw_texel,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ttdd_pkg::t_pix       o_pixel_x,
    output ttdd_pkg::t_pix       o_pixel_y,
    output ttdd_pkg::t_chan      o_alpha,
    output ttdd_pkg::t_chan      o_red,
    output ttdd_pkg::t_chan      o_green,
    output ttdd_pkg::t_chan      o_blue,
    output logic                 o_frame_done
);

    ttdd_pkg::t_fmt  r_fmt;
    ttdd_pkg::t_geom r_geom;

    ttdd_pkg::t_cdim cfg_dim;
    logic            cfg_we;

    logic            push;
    ttdd_pkg::t_item push_item;
    logic            q_full;
    logic            pop;
    logic            q_not_empty;
    ttdd_pkg::t_item q_item;

    // Configuration registers; the tile counts are worked out once at the write.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_dim     = ttdd_pkg::clamp_dim(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt           <= ttdd_pkg::FMT_IA8;
            r_geom.width    <= ttdd_pkg::t_cdim'(ttdd_pkg::TILE_SIZE);
            r_geom.height   <= ttdd_pkg::t_cdim'(ttdd_pkg::TILE_SIZE);
            r_geom.last_col <= '0;
            r_geom.last_row <= '0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                ttdd_pkg::CFG_FORMAT: begin
                    r_fmt <= i_cfg_data[ttdd_pkg::FMT_W-1:0];
                end
                ttdd_pkg::CFG_WIDTH: begin
                    r_geom.width    <= cfg_dim;
                    r_geom.last_col <= ttdd_pkg::last_tile(cfg_dim);
                end
                ttdd_pkg::CFG_HEIGHT: begin
                    r_geom.height   <= cfg_dim;
                    r_geom.last_row <= ttdd_pkg::last_tile(cfg_dim);
                end
                default: begin
                    r_fmt <= r_fmt;
                end
            endcase
        end
    end

    ttdd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_raw_texel (i_raw_texel),
        .i_geom      (r_geom),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    ttdd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_pop_item  (q_item)
    );

    ttdd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_format (r_fmt),
        .i_q_not_empty  (q_not_empty),
        .i_q_item       (q_item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_alpha        (o_alpha),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_frame_done   (o_frame_done)
    );

endmodule
